>>> hw/rtl/ihdt_pkg.sv
// Shared types, codes and the rank compare for the indexed max-heap unit.
// No dependencies.
package ihdt_pkg;

	localparam int ID_BITS     = 10;
	localparam int KEY_BITS    = 32;
	localparam int DEGREE_BITS = 16;
	localparam int FUNC_BITS   = 2;
	localparam int STATUS_BITS = 3;
	localparam int COUNT_BITS  = 11;

	localparam logic [FUNC_BITS-1:0] FN_INSERT   = 2'd0;
	localparam logic [FUNC_BITS-1:0] FN_INCREASE = 2'd1;
	localparam logic [FUNC_BITS-1:0] FN_EXTRACT  = 2'd2;

	localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_UNDER   = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_PRESENT = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_ABSENT  = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd4;

	typedef struct packed {
		logic [FUNC_BITS-1:0]   func;
		logic [ID_BITS-1:0]     item_id;
		logic [KEY_BITS-1:0]    key_value;
		logic [DEGREE_BITS-1:0] degree;
	} in_word_t;

	typedef struct packed {
		logic [ID_BITS-1:0]     result_id;
		logic [STATUS_BITS-1:0] status;
		logic [COUNT_BITS-1:0]  heap_count;
	} out_word_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_LATCH,
		OP_FIN,
		OP_INS,
		OP_INC,
		OP_INC_DEG,
		OP_EXT_TOP,
		OP_EXT_LAST,
		OP_EXT_KEYS,
		OP_UP_RD,
		OP_UP_KEY,
		OP_UP_MOVE,
		OP_DN_RD,
		OP_DN_LKEY,
		OP_DN_LCMP,
		OP_DN_RCMP,
		OP_DN_MOVE,
		OP_PLACE_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t                 op;
		logic [STATUS_BITS-1:0] fin_status;
	} dp_cmd_t;

	typedef struct packed {
		logic                 clr_last;
		logic [FUNC_BITS-1:0] func;
		logic                 id_ok;
		logic                 slot_zero;
		logic                 slot_over;
		logic                 full;
		logic                 empty;
		logic                 pos_root;
		logic                 mv_beats_rd;
		logic                 go_down;
		logic                 l_out;
		logic                 r_in;
		logic                 best_child;
	} dp_stat_t;

	// a ranks strictly above b
	function automatic logic beats(
		input logic [KEY_BITS-1:0]    ka,
		input logic [DEGREE_BITS-1:0] da,
		input logic [KEY_BITS-1:0]    kb,
		input logic [DEGREE_BITS-1:0] db
	);
		return (ka > kb) || ((ka == kb) && (da > db));
	endfunction

endpackage

>>> hw/rtl/indexed_max_heap_degree_tiebreak_unit.sv
// Top level of the indexed max-heap with degree tie-break.
// Depends on ihdt_pkg, ihdt_ctrl, ihdt_dp (and ihdt_ram through ihdt_dp).
//
// channel | handshake          | word
// --------+--------------------+---------------------------------------
// input   | start, busy        | request (func, item_id, key, degree)
// output  | done (strobe)      | result (result_id, status, heap_count)
//
// After reset, busy stays high while the position table is cleared.
// Errors and no-op codes finish from the check state; done rises in the cycle after they finish.
// Sift up steps S_UP0, S_UP1, S_UP2 per level; sift down steps S_DN0 to S_DN4 per level,
// skipping S_DN3 without a right child (one RAM read port each).
// done is a one-cycle strobe; a new word may be started in the done cycle.
module indexed_max_heap_degree_tiebreak_unit import ihdt_pkg::*; #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_word_t  request,
	output logic      busy,
	output logic      done,
	output out_word_t result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ihdt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.cmd(cmd), .busy(busy), .done(done)
	);

	ihdt_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .request(request), .cmd(cmd),
		.stat(stat), .result(result)
	);

endmodule

>>> hw/rtl/ihdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ihdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/ihdt_dp.sv
// Datapath of the heap unit: heap, position, key and degree memories,
// sift registers and result word. Depends on ihdt_pkg and ihdt_ram.
module ihdt_dp import ihdt_pkg::*; #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  request,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output out_word_t result
);

	localparam int SW = $clog2(MAX_ITEMS + 1);
	localparam int IW = $clog2(MAX_ITEMS);

	in_word_t               in_q;
	out_word_t              out_q;
	logic [SW-1:0]          count_q, pos_q, best_pos_q;
	logic [IW-1:0]          clr_q, mv_id_q, top_q, par_id_q, l_id_q, r_id_q, best_id_q;
	logic [KEY_BITS-1:0]    mv_key_q, best_key_q;
	logic [DEGREE_BITS-1:0] mv_deg_q, best_deg_q;
	logic                   moved_q, best_child_q;

	logic [IW-1:0]          id_idx, heap_rd, heap_wd, slot_wa, key_ra;
	logic [SW-1:0]          slot_rd, slot_wd, heap_wa, heap_ra;
	logic [KEY_BITS-1:0]    key_rd;
	logic [DEGREE_BITS-1:0] deg_rd;
	logic                   heap_we, slot_we, key_we, deg_we;
	logic [SW:0]            l_pos, r_pos;

	assign id_idx = IW'(in_q.item_id);
	assign l_pos  = {pos_q, 1'b0};
	assign r_pos  = {pos_q, 1'b1};
	assign key_ra = (cmd.op == OP_INC) ? id_idx : heap_rd;
	assign key_we = (cmd.op == OP_INS) || (cmd.op == OP_INC);
	assign deg_we = (cmd.op == OP_INS);

	always_comb begin
		heap_we = 1'b0;
		heap_wa = pos_q;
		heap_wd = mv_id_q;
		slot_we = 1'b0;
		slot_wa = mv_id_q;
		slot_wd = pos_q;
		case (cmd.op)
			OP_UP_MOVE: begin
				heap_we = 1'b1;
				heap_wd = par_id_q;
				slot_we = 1'b1;
				slot_wa = par_id_q;
			end
			OP_DN_MOVE: begin
				heap_we = 1'b1;
				heap_wd = best_id_q;
				slot_we = 1'b1;
				slot_wa = best_id_q;
			end
			OP_PLACE_FIN: begin
				heap_we = 1'b1;
				slot_we = 1'b1;
			end
			OP_CLR: begin
				slot_we = 1'b1;
				slot_wa = clr_q;
				slot_wd = '0;
			end
			OP_EXT_LAST: begin
				slot_we = 1'b1;
				slot_wa = top_q;
				slot_wd = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (cmd.op)
			OP_EXT_TOP: heap_ra = count_q;
			OP_UP_RD:   heap_ra = pos_q >> 1;
			OP_DN_RD:   heap_ra = SW'(l_pos);
			OP_DN_LKEY: heap_ra = SW'(r_pos);
			default:    heap_ra = SW'(1);
		endcase
	end

	ihdt_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS + 1)) u_heap (
		.clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
		.raddr(heap_ra), .rdata(heap_rd)
	);

	ihdt_ram #(.WIDTH(SW), .DEPTH(MAX_ITEMS)) u_slot (
		.clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
		.raddr(IW'(request.item_id)), .rdata(slot_rd)
	);

	ihdt_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ITEMS)) u_key (
		.clk(clk), .we(key_we), .waddr(id_idx), .wdata(in_q.key_value),
		.raddr(key_ra), .rdata(key_rd)
	);

	ihdt_ram #(.WIDTH(DEGREE_BITS), .DEPTH(MAX_ITEMS)) u_deg (
		.clk(clk), .we(deg_we), .waddr(id_idx), .wdata(in_q.degree),
		.raddr(key_ra), .rdata(deg_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			case (cmd.op)
				OP_CLR:      clr_q   <= clr_q + 1'b1;
				OP_INS:      count_q <= count_q + 1'b1;
				OP_EXT_LAST: count_q <= count_q - 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH:   in_q  <= request;
			OP_EXT_TOP: top_q <= heap_rd;
			OP_INS: begin
				pos_q    <= count_q + 1'b1;
				mv_id_q  <= id_idx;
				mv_key_q <= in_q.key_value;
				mv_deg_q <= in_q.degree;
				moved_q  <= 1'b0;
			end
			OP_INC: begin
				pos_q    <= slot_rd;
				mv_id_q  <= id_idx;
				mv_key_q <= in_q.key_value;
				moved_q  <= 1'b0;
			end
			OP_INC_DEG: mv_deg_q <= deg_rd;
			OP_EXT_LAST: begin
				mv_id_q <= heap_rd;
				pos_q   <= SW'(1);
			end
			OP_EXT_KEYS: begin
				mv_key_q <= key_rd;
				mv_deg_q <= deg_rd;
			end
			OP_UP_KEY: par_id_q <= heap_rd;
			OP_UP_MOVE: begin
				pos_q   <= pos_q >> 1;
				moved_q <= 1'b1;
			end
			OP_DN_LKEY: l_id_q <= heap_rd;
			OP_DN_LCMP: begin
				r_id_q <= heap_rd;
				if (beats(key_rd, deg_rd, mv_key_q, mv_deg_q)) begin
					best_id_q    <= l_id_q;
					best_key_q   <= key_rd;
					best_deg_q   <= deg_rd;
					best_pos_q   <= SW'(l_pos);
					best_child_q <= 1'b1;
				end else begin
					best_key_q   <= mv_key_q;
					best_deg_q   <= mv_deg_q;
					best_child_q <= 1'b0;
				end
			end
			OP_DN_RCMP: begin
				if (beats(key_rd, deg_rd, best_key_q, best_deg_q)) begin
					best_id_q    <= r_id_q;
					best_pos_q   <= SW'(r_pos);
					best_child_q <= 1'b1;
				end
			end
			OP_DN_MOVE: pos_q <= best_pos_q;
			OP_FIN, OP_PLACE_FIN: begin
				out_q.result_id  <= ((in_q.func == FN_EXTRACT) && (cmd.fin_status == ST_OK)) ?
					ID_BITS'(top_q) : '0;
				out_q.status     <= cmd.fin_status;
				out_q.heap_count <= COUNT_BITS'(count_q);
			end
			default: begin
			end
		endcase
	end

	assign stat.clr_last    = (clr_q == IW'(MAX_ITEMS - 1));
	assign stat.func        = in_q.func;
	assign stat.id_ok       = (32'(in_q.item_id) < 32'(MAX_ITEMS));
	assign stat.slot_zero   = (slot_rd == '0);
	assign stat.slot_over   = (slot_rd > count_q);
	assign stat.full        = (count_q == SW'(MAX_ITEMS));
	assign stat.empty       = (count_q == '0);
	assign stat.pos_root    = (pos_q == SW'(1));
	assign stat.mv_beats_rd = beats(mv_key_q, mv_deg_q, key_rd, deg_rd);
	assign stat.go_down     = (in_q.func == FN_INCREASE) && !moved_q;
	assign stat.l_out       = (l_pos > {1'b0, count_q});
	assign stat.r_in        = (r_pos <= {1'b0, count_q});
	assign stat.best_child  = best_child_q;

	assign result = out_q;

endmodule

>>> hw/rtl/ihdt_ctrl.sv
// Controller state machine of the heap unit: checks, sift up and sift down.
// Depends on ihdt_pkg.
module ihdt_ctrl import ihdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy,
	output logic     done
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LOOK, S_INC_DEG, S_EXT_LAST, S_EXT_KEYS,
		S_UP0, S_UP1, S_UP2, S_DN0, S_DN1, S_DN2, S_DN3, S_DN4
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	function automatic dp_cmd_t fin(input logic [STATUS_BITS-1:0] st);
		return '{op: OP_FIN, fin_status: st};
	endfunction

	always_comb begin
		cmd     = '{op: OP_NONE, fin_status: ST_OK};
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				cmd.op = OP_CLR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LATCH;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_IDLE;
				case (stat.func)
					FN_INSERT: begin
						if (!stat.id_ok) begin
							cmd = fin(ST_FULL);
						end else if (!stat.slot_zero) begin
							cmd = fin(ST_PRESENT);
						end else if (stat.full) begin
							cmd = fin(ST_FULL);
						end else begin
							cmd.op  = OP_INS;
							state_d = S_UP0;
						end
					end
					FN_INCREASE: begin
						if (!stat.id_ok || stat.slot_zero || stat.slot_over) begin
							cmd = fin(ST_ABSENT);
						end else begin
							cmd.op  = OP_INC;
							state_d = S_INC_DEG;
						end
					end
					FN_EXTRACT: begin
						if (stat.empty) begin
							cmd = fin(ST_UNDER);
						end else begin
							cmd.op  = OP_EXT_TOP;
							state_d = S_EXT_LAST;
						end
					end
					default: cmd = fin(ST_OK);
				endcase
			end
			S_INC_DEG: begin
				cmd.op  = OP_INC_DEG;
				state_d = S_UP0;
			end
			S_EXT_LAST: begin
				cmd.op  = OP_EXT_LAST;
				state_d = S_EXT_KEYS;
			end
			S_EXT_KEYS: begin
				if (stat.empty) begin
					cmd     = fin(ST_OK);
					state_d = S_IDLE;
				end else begin
					cmd.op  = OP_EXT_KEYS;
					state_d = S_DN0;
				end
			end
			S_UP0: begin
				if (!stat.pos_root) begin
					cmd.op  = OP_UP_RD;
					state_d = S_UP1;
				end else if (stat.go_down) begin
					state_d = S_DN0;
				end else begin
					cmd.op  = OP_PLACE_FIN;
					state_d = S_IDLE;
				end
			end
			S_UP1: begin
				cmd.op  = OP_UP_KEY;
				state_d = S_UP2;
			end
			S_UP2: begin
				if (stat.mv_beats_rd) begin
					cmd.op  = OP_UP_MOVE;
					state_d = S_UP0;
				end else if (stat.go_down) begin
					state_d = S_DN0;
				end else begin
					cmd.op  = OP_PLACE_FIN;
					state_d = S_IDLE;
				end
			end
			S_DN0: begin
				if (stat.l_out) begin
					cmd.op  = OP_PLACE_FIN;
					state_d = S_IDLE;
				end else begin
					cmd.op  = OP_DN_RD;
					state_d = S_DN1;
				end
			end
			S_DN1: begin
				cmd.op  = OP_DN_LKEY;
				state_d = S_DN2;
			end
			S_DN2: begin
				cmd.op  = OP_DN_LCMP;
				state_d = stat.r_in ? S_DN3 : S_DN4;
			end
			S_DN3: begin
				cmd.op  = OP_DN_RCMP;
				state_d = S_DN4;
			end
			S_DN4: begin
				if (stat.best_child) begin
					cmd.op  = OP_DN_MOVE;
					state_d = S_DN0;
				end else begin
					cmd.op  = OP_PLACE_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (cmd.op == OP_FIN) || (cmd.op == OP_PLACE_FIN);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("word out while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not start work");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("two result words back to back");
`endif

endmodule
